[src/lbp_grid_histogram_core_defines.svh]
// lbp_grid_histogram_core_defines.svh: assertion macros for the lbp grid histogram core
// no dependencies; expects clk and rst in the scope of each use
`ifndef LBP_GRID_HISTOGRAM_CORE_DEFINES_SVH
`define LBP_GRID_HISTOGRAM_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

`define LBP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lbp_grid: property failed");

`define LBP_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("lbp_grid: forbidden condition seen");

`else

`define LBP_ASSERT(label, prop)

`define LBP_ASSERT_NEVER(label, cond)

`endif

`endif

[src/lbp_grid_pkg.sv]
// lbp_grid_pkg.sv: types and fixed constants of the lbp grid histogram core
// no dependencies
package lbp_grid_pkg;

  localparam int GRID_X     = 4;
  localparam int GRID_Y     = 4;
  localparam int CELLS      = GRID_X * GRID_Y;
  localparam int BINS       = 32;
  localparam int COUNT_BITS = 12;

  localparam int PIX_W  = 8;
  localparam int CODE_W = 8;
  localparam int DIM_W  = 9;
  localparam int CELL_W = 4;
  localparam int BIN_W  = 5;
  localparam int GX_W   = $clog2(GRID_X);
  localparam int GY_W   = $clog2(GRID_Y);

  localparam int HIST_DEPTH = CELLS * BINS;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX    = '1;
  localparam logic [DIM_W-1:0]      WIDTH_RESET  = 9'd136;
  localparam logic [DIM_W-1:0]      HEIGHT_RESET = 9'd36;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_START = 2'd2
  } lbp_op_t;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } lbp_reg_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } lbp_state_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [PIX_W-1:0]  gray_pixel;
    logic [CELL_W-1:0] cell_index;
    logic [BIN_W-1:0]  bin_index;
  } lbp_in_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] bin_count;
    logic                  image_complete;
  } lbp_out_t;

endpackage

[src/lbp_grid_ram.sv]
// lbp_grid_ram.sv: generic single-write, single-read ram with registered read data
// no dependencies
module lbp_grid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/lbp_grid_window.sv]
// lbp_grid_window.sv: line stores, 3x3 window and pattern code of the lbp grid core
// depends on lbp_grid_pkg and lbp_grid_ram
module lbp_grid_window
  import lbp_grid_pkg::*;
#(
  parameter int MAX_WIDTH = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [$clog2(MAX_WIDTH)-1:0] col,
  input  logic [PIX_W-1:0]             pix,
  output logic                         code_valid,
  output logic [CODE_W-1:0]            code
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int LS_W  = 2 * PIX_W;

  logic             stage_v;
  logic [COL_W-1:0] col_q;
  logic [PIX_W-1:0] pix_q;
  logic             fwd;
  logic [LS_W-1:0]  fwd_data;
  logic [LS_W-1:0]  ls_rdata;
  logic [LS_W-1:0]  ls_wdata;
  logic [PIX_W-1:0] up_px;
  logic [PIX_W-1:0] lo_px;
  logic [PIX_W-1:0] win_a [3];
  logic [PIX_W-1:0] win_b [3];
  logic [PIX_W-1:0] centre;

  // upper and lower line share one word per column
  lbp_grid_ram #(
    .WIDTH (LS_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (stage_v),
    .waddr (col_q),
    .wdata (ls_wdata),
    .raddr (col),
    .rdata (ls_rdata)
  );

  assign {up_px, lo_px} = fwd ? fwd_data : ls_rdata;
  assign ls_wdata       = {lo_px, pix_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= 1'b0;
      fwd     <= 1'b0;
    end else begin
      stage_v <= push;
      fwd     <= push && stage_v && (col == col_q);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      col_q <= col;
      pix_q <= pix;
    end
    fwd_data <= ls_wdata;
  end

  // win_a and win_b hold the two older window columns
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        win_a[i] <= '0;
        win_b[i] <= '0;
      end
    end else if (stage_v) begin
      for (int i = 0; i < 3; i++) begin
        win_a[i] <= win_b[i];
      end
      win_b[0] <= up_px;
      win_b[1] <= lo_px;
      win_b[2] <= pix_q;
    end
  end

  assign centre = win_b[1];

  always_comb begin
    code    = '0;
    code[7] = win_a[0] >= centre;
    code[6] = win_b[0] >= centre;
    code[5] = up_px    >= centre;
    code[4] = lo_px    >= centre;
    code[3] = pix_q    >= centre;
    code[2] = win_b[2] >= centre;
    code[1] = win_a[2] >= centre;
    code[0] = win_a[1] >= centre;
  end

  assign code_valid = stage_v;

endmodule

[src/lbp_grid_histogram_core.sv]
// lbp_grid_histogram_core.sv: top level of the lbp spatial histogram core
// depends on lbp_grid_pkg, lbp_grid_window, lbp_grid_ram and the defines header
//
// Usage:
// The input channel (in_valid/in_ready/in_data) carries one operation per beat:
// push a grey pixel in raster order, read one histogram bin, or start a new image.
// Only a read produces an output beat (out_valid/out_ready/out_data), holding the
// bin count and whether the whole image has been pushed.
// Image width and height are set through cfg_write/cfg_index/cfg_data, which the
// user must write only while idle; the core itself does not enforce this.
// Throughput is one beat per cycle for any mix of pushes and reads while in_ready is
// high; the histogram is a simple dual-port ram updated read-modify-write over two
// stages, with forwarding between back-to-back updates of the same bin.
// Up to four read results can wait in the output queue; once it is full, and
// reads in flight count against it, in_ready drops until out_ready takes a beat.
// After reset, and after every start beat, all 512 histogram entries are cleared one
// entry a cycle, once beats already in flight have drained.
// in_ready stays low during that pass; configuration writes are still taken.
// Reset also clears the row and column counters and the window.
`include "lbp_grid_histogram_core_defines.svh"

module lbp_grid_histogram_core
  import lbp_grid_pkg::*;
#(
  parameter int MAX_WIDTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lbp_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lbp_out_t         out_data,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [DIM_W-1:0] cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int EW    = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
  localparam int TXW   = EW + GX_W + 1;
  localparam int TYW   = DIM_W + GY_W + 1;
  localparam logic [FIFO_CW:0] SLOTS_MAX = (FIFO_CW + 1)'(FIFO_DEPTH);

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;

  logic [COL_W-1:0] col_cnt;
  logic [DIM_W-1:0] row_cnt;

  lbp_state_t       state;
  lbp_state_t       state_next;
  logic [HIST_AW-1:0] clr_addr;
  logic             clr_we;

  logic acc;
  logic acc_push;
  logic acc_read;
  logic acc_start;
  logic row_live;

  logic [EW-1:0]    w_eff;
  logic [EW-1:0]    cw;
  logic [EW-1:0]    x_pos;
  logic [DIM_W-1:0] ch;
  logic [DIM_W-1:0] y_pos;
  logic [GX_W-1:0]  gx;
  logic [GY_W-1:0]  gy;
  logic             gx_in;
  logic             gy_in;
  logic             code_en;
  logic [CELL_W-1:0] cell_num;

  logic              code_valid;
  logic [CODE_W-1:0] code;

  logic              s1_read;
  logic              s1_cell_ok;
  logic [CELL_W-1:0] s1_cell;
  logic [BIN_W-1:0]  s1_bin;
  logic              s1_range_ok;
  logic              s1_ic;
  logic              s1_upd;

  logic                  s2_upd;
  logic                  s2_read;
  logic [HIST_AW-1:0]    s2_addr;
  logic                  s2_range_ok;
  logic                  s2_ic;
  logic                  hist_fwd;
  logic [COUNT_BITS-1:0] hist_fwd_data;

  logic [HIST_AW-1:0]    hist_raddr;
  logic [COUNT_BITS-1:0] hist_rdata;
  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] hist_wdata;
  logic                  hist_we;
  logic [HIST_AW-1:0]    hist_waddr;
  logic [COUNT_BITS-1:0] hist_wdata_mux;

  lbp_out_t           fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] fifo_count;
  logic               fifo_push;
  logic               fifo_pop;
  logic [FIFO_CW:0]   slots_used;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // input handshake
  assign slots_used = {1'b0, fifo_count} + (FIFO_CW + 1)'(s1_read) + (FIFO_CW + 1)'(s2_read);
  assign in_ready   = (state == ST_RUN) && (slots_used < SLOTS_MAX);
  assign acc        = in_valid && in_ready;
  assign acc_push   = acc && (in_data.operation == OP_PUSH);
  assign acc_read   = acc && (in_data.operation == OP_READ);
  assign acc_start  = acc && (in_data.operation == OP_START);
  assign row_live   = row_cnt < image_height;

  // position and grid cell of the code this pixel completes
  assign w_eff = (EW'(image_width) > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(image_width);
  assign cw    = EW'((w_eff - EW'(2)) / GRID_X);
  assign ch    = DIM_W'((image_height - DIM_W'(2)) / GRID_Y);
  assign x_pos = EW'(col_cnt) - EW'(2);
  assign y_pos = row_cnt - DIM_W'(2);

  always_comb begin
    gx = '0;
    gy = '0;
    for (int k = 1; k < GRID_X; k++) begin
      if (TXW'(x_pos) >= TXW'(cw) * TXW'(k)) begin
        gx = gx + 1'b1;
      end
    end
    for (int k = 1; k < GRID_Y; k++) begin
      if (TYW'(y_pos) >= TYW'(ch) * TYW'(k)) begin
        gy = gy + 1'b1;
      end
    end
    gx_in = TXW'(x_pos) < TXW'(cw) * TXW'(GRID_X);
    gy_in = TYW'(y_pos) < TYW'(ch) * TYW'(GRID_Y);
  end

  assign cell_num = CELL_W'(int'(gy) * GRID_X + int'(gx));
  assign code_en  = row_live && (row_cnt >= DIM_W'(2)) && (col_cnt >= COL_W'(2)) &&
                    (w_eff >= EW'(3)) && (image_height >= DIM_W'(3)) &&
                    (cw != '0) && (ch != '0) && gx_in && gy_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (acc_start) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (acc_push && row_live) begin
      if (EW'(col_cnt) + EW'(1) >= w_eff) begin
        col_cnt <= '0;
        row_cnt <= row_cnt + 1'b1;
      end else begin
        col_cnt <= col_cnt + 1'b1;
      end
    end
  end

  lbp_grid_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .push       (acc_push && row_live),
    .col        (col_cnt),
    .pix        (in_data.gray_pixel),
    .code_valid (code_valid),
    .code       (code)
  );

  // stage 1: code ready, histogram read issued
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_read <= 1'b0;
    end else begin
      s1_read <= acc_read;
    end
  end

  always_ff @(posedge clk) begin
    s1_cell     <= acc_read ? in_data.cell_index : cell_num;
    s1_bin      <= in_data.bin_index;
    s1_cell_ok  <= code_en;
    s1_range_ok <= (int'(in_data.cell_index) < CELLS) && (int'(in_data.bin_index) < BINS);
    s1_ic       <= row_cnt >= image_height;
  end

  assign s1_upd     = code_valid && s1_cell_ok && (int'(code) < BINS);
  assign hist_raddr = HIST_AW'(int'(s1_cell) * BINS +
                               (s1_read ? int'(s1_bin) : int'(code)));

  // stage 2: modify and write back
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_upd   <= 1'b0;
      s2_read  <= 1'b0;
      hist_fwd <= 1'b0;
    end else begin
      s2_upd   <= s1_upd;
      s2_read  <= s1_read;
      hist_fwd <= s2_upd && (s2_addr == hist_raddr);
    end
  end

  always_ff @(posedge clk) begin
    s2_addr       <= hist_raddr;
    s2_range_ok   <= s1_range_ok;
    s2_ic         <= s1_ic;
    hist_fwd_data <= hist_wdata;
  end

  assign cnt        = hist_fwd ? hist_fwd_data : hist_rdata;
  assign hist_wdata = (cnt == COUNT_MAX) ? cnt : cnt + 1'b1;

  // clearing pass waits for the pipeline ahead to drain
  assign clr_we = (state == ST_CLEAR) && !code_valid && !s1_read && !s2_upd && !s2_read;

  assign hist_we        = s2_upd || clr_we;
  assign hist_waddr     = clr_we ? clr_addr : s2_addr;
  assign hist_wdata_mux = clr_we ? '0 : hist_wdata;

  lbp_grid_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata_mux),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (acc_start) begin
        clr_addr <= '0;
      end else if (clr_we) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (acc_start) begin
          state_next = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (clr_we && (clr_addr == HIST_AW'(HIST_DEPTH - 1))) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // result queue
  assign fifo_push = s2_read;
  assign fifo_pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (fifo_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (fifo_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({fifo_push, fifo_pop})
        2'b10:   fifo_count <= fifo_count + 1'b1;
        2'b01:   fifo_count <= fifo_count - 1'b1;
        default: fifo_count <= fifo_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_push) begin
      fifo_mem[wr_ptr].bin_count      <= s2_range_ok ? cnt : '0;
      fifo_mem[wr_ptr].image_complete <= s2_ic;
    end
  end

  assign out_valid = fifo_count != '0;
  assign out_data  = fifo_mem[rd_ptr];

  `LBP_ASSERT(a_slots_bounded, slots_used <= SLOTS_MAX)
  `LBP_ASSERT(a_start_resets, acc_start |=> (col_cnt == '0 && row_cnt == '0 && state == ST_CLEAR))
  `LBP_ASSERT(a_clear_after_drain, (state == ST_CLEAR && clr_addr != '0) |-> !s2_upd)
  `LBP_ASSERT_NEVER(a_queue_overflow, fifo_push && !fifo_pop && fifo_count == FIFO_CW'(FIFO_DEPTH))

endmodule
